[src/bill_validator_link_handler_assert.svh]
// Assertion macros for the bill validator link handler.
`ifndef BILL_VALIDATOR_LINK_HANDLER_ASSERT_SVH
`define BILL_VALIDATOR_LINK_HANDLER_ASSERT_SVH

`ifndef ASSERT_OFF

// a holds in this cycle -> b holds in the same cycle
`define BVLH_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("bvlh assertion failed");

// a holds in this cycle -> b holds in the next cycle
`define BVLH_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("bvlh assertion failed");

`else

`define BVLH_ASSERT_SAME(label, clk, rst_n, a, b)
`define BVLH_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

[src/bvlh_pkg.sv]
`timescale 1ns / 1ps

package bvlh_pkg;

    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_U         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_WINDOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_TICKS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_GAP      = 3'd6;
    localparam int CFG_DATA_W = 14;

    // validator byte codes
    localparam logic [7:0] BYTE_NULL      = 8'h00;
    localparam logic [7:0] BYTE_IDLE      = 8'hFF;
    localparam logic [7:0] BYTE_SUSPECT   = 8'h2F;
    localparam logic [7:0] BYTE_STACKED   = 8'h10;
    localparam logic [7:0] BYTE_NOTE_BASE = 8'h40;
    localparam logic [7:0] BYTE_NOTE_LAST = 8'h44;
    localparam logic [7:0] BYTE_PWR_HDR   = 8'h80;
    localparam logic [7:0] BYTE_NOTE_HDR  = 8'h81;
    localparam logic [7:0] BYTE_ESC       = 8'h8F;
    localparam logic [7:0] BYTE_V_PWR_A   = 8'h56;
    localparam logic [7:0] BYTE_V_PWR_B   = 8'h4E;
    localparam logic [7:0] BYTE_ACCEPT    = 8'h02;
    localparam logic [7:0] BYTE_REJECT    = 8'h0F;

    // outcome codes
    localparam logic [2:0] OUT_NONE     = 3'd0;
    localparam logic [2:0] OUT_POWER_ON = 3'd1;
    localparam logic [2:0] OUT_STACKED  = 3'd2;
    localparam logic [2:0] OUT_REJECTED = 3'd3;
    localparam logic [2:0] OUT_TIMEOUT  = 3'd4;

    // configuration reset values
    localparam logic [13:0] RST_LOCK_WINDOW    = 14'd10000;
    localparam logic [7:0]  RST_LOCK_THRESHOLD = 8'd3;
    localparam logic [13:0] RST_RESULT_TIMEOUT = 14'd5000;
    localparam logic [7:0]  RST_SETTLE_TICKS   = 8'd20;
    localparam logic [7:0]  RST_QUIET_TICKS    = 8'd5;
    localparam logic [7:0]  RST_BURST_GAP      = 8'd20;

    typedef struct packed {
        logic        mode_u;
        logic [13:0] lock_window;
        logic [7:0]  lock_threshold;
        logic [13:0] result_timeout;
        logic [7:0]  settle_ticks;
        logic [7:0]  quiet_ticks;
        logic [7:0]  burst_gap;
    } bvlh_cfg_t;

    // classified input transaction
    typedef struct packed {
        logic       is_tick;
        logic [7:0] rx_byte;
        logic       filler;
        logic       suspect;
        logic       stacked;
        logic       note_code;
        logic [2:0] note_ch;
    } bvlh_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [2:0]  outcome;
        logic [2:0]  note_channel;
        logic [16:0] note_value;
    } bvlh_result_t;

    function automatic logic [16:0] face_value(input logic [2:0] ch);
        logic [16:0] v;
        case (ch)
            3'd0:    v = 17'd5000;
            3'd1:    v = 17'd10000;
            3'd2:    v = 17'd20000;
            3'd3:    v = 17'd50000;
            3'd4:    v = 17'd100000;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

[src/bvlh_if.sv]
`timescale 1ns / 1ps

interface bvlh_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface bvlh_rsp_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [2:0]  outcome;
    logic [2:0]  note_channel;
    logic [16:0] note_value;

    modport source (output valid, output tx_valid, output tx_byte, output outcome,
                    output note_channel, output note_value, input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input outcome,
                    input note_channel, input note_value, output ready);
endinterface

[src/bill_validator_link_handler.sv]
// Bill validator link handler.
// Input channel req: one transaction per received validator byte (req_type 0)
// or per 1 ms tick (req_type 1). Output channel rsp: exactly one result per
// input transaction, in order: an optional byte to send to the validator
// (accept 0x02 / reject 0x0F) plus an outcome code, note channel and value.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// the user must write only while the block is idle; it is not enforced.
// Structure: the front classifies each transaction and pushes it into a
// QUEUE_DEPTH-entry queue; the back runs the protocol state machine into a
// registered output slot, one queue entry per cycle while the slot can take it.
// Path: an accepted transaction is registered into the queue, then popped
// by the back into the registered output slot, which drives rsp.valid.
// Throughput: one transaction per cycle while the output slot can take it.
// Reset: control and config registers take their defaults (not result data
// or queue slots), history, lockout and queue cleared, phase to pattern hunt.
// Receiver stall: the output slot holds its result; the back stops popping,
// the queue fills, then req.ready drops until the slot is taken.
`timescale 1ns / 1ps
`include "bill_validator_link_handler_assert.svh"

module bill_validator_link_handler #(
    parameter int QUEUE_DEPTH = bvlh_pkg::QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    bvlh_req_if.sink                           req,
    bvlh_rsp_if.source                         rsp,
    input  logic                               cfg_we,
    input  logic [bvlh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bvlh_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bvlh_pkg::*;

    bvlh_cfg_t  cfg_reg;
    bvlh_item_t front_item;
    bvlh_item_t head_item;
    logic       push;
    logic       q_full;
    logic       q_not_empty;
    logic       pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_u         <= 1'b1;
            cfg_reg.lock_window    <= RST_LOCK_WINDOW;
            cfg_reg.lock_threshold <= RST_LOCK_THRESHOLD;
            cfg_reg.result_timeout <= RST_RESULT_TIMEOUT;
            cfg_reg.settle_ticks   <= RST_SETTLE_TICKS;
            cfg_reg.quiet_ticks    <= RST_QUIET_TICKS;
            cfg_reg.burst_gap      <= RST_BURST_GAP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE_U:         cfg_reg.mode_u         <= cfg_data[0];
                REG_LOCK_WINDOW:    cfg_reg.lock_window    <= cfg_data[13:0];
                REG_LOCK_THRESHOLD: cfg_reg.lock_threshold <= cfg_data[7:0];
                REG_RESULT_TIMEOUT: cfg_reg.result_timeout <= cfg_data[13:0];
                REG_SETTLE_TICKS:   cfg_reg.settle_ticks   <= cfg_data[7:0];
                REG_QUIET_TICKS:    cfg_reg.quiet_ticks    <= cfg_data[7:0];
                REG_BURST_GAP:      cfg_reg.burst_gap      <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    bvlh_front u_front (
        .req    (req),
        .q_full (q_full),
        .push   (push),
        .item   (front_item)
    );

    bvlh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    bvlh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_not_empty),
        .q_item  (head_item),
        .pop     (pop),
        .rsp     (rsp)
    );

    // an accepted transaction is queued for the back
    `BVLH_ASSERT_NEXT(a_push_queued, clk, rst_n, req.valid && req.ready, q_not_empty)
    // the back only advances when the output slot can take the result
    `BVLH_ASSERT_SAME(a_pop_slot_free, clk, rst_n, pop, !rsp.valid || rsp.ready)
    // every popped transaction shows up as a result
    `BVLH_ASSERT_NEXT(a_pop_result, clk, rst_n, pop, rsp.valid)

endmodule

[src/bvlh_front.sv]
`timescale 1ns / 1ps

module bvlh_front (
    bvlh_req_if.sink          req,
    input  logic              q_full,
    output logic              push,
    output bvlh_pkg::bvlh_item_t item
);
    import bvlh_pkg::*;

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    always_comb
    begin
        item.is_tick   = req.req_type;
        item.rx_byte   = req.rx_byte;
        item.filler    = (req.rx_byte == BYTE_NULL) || (req.rx_byte == BYTE_IDLE);
        item.suspect   = (req.rx_byte == BYTE_SUSPECT);
        item.stacked   = (req.rx_byte == BYTE_STACKED);
        item.note_code = (req.rx_byte >= BYTE_NOTE_BASE) && (req.rx_byte <= BYTE_NOTE_LAST);
        // 0x40..0x44 -> channel in the low bits
        item.note_ch   = req.rx_byte[2:0];
    end

endmodule

[src/bvlh_fifo.sv]
`timescale 1ns / 1ps

module bvlh_fifo #(
    parameter int DEPTH = bvlh_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bvlh_pkg::bvlh_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output bvlh_pkg::bvlh_item_t head_item
);
    import bvlh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bvlh_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[src/bvlh_back.sv]
`timescale 1ns / 1ps

module bvlh_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bvlh_pkg::bvlh_cfg_t  cfg,
    input  logic                 q_valid,
    input  bvlh_pkg::bvlh_item_t q_item,
    output logic                 pop,
    bvlh_rsp_if.source           rsp
);
    import bvlh_pkg::*;

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_SETTLE = 2'd1;
    localparam logic [1:0] PH_DRAIN  = 2'd2;
    localparam logic [1:0] PH_AWAIT  = 2'd3;

    logic [7:0]   hist_reg [4];
    logic [7:0]   hist_next [4];
    logic [2:0]   fill_reg, fill_next;
    logic [1:0]   phase_reg, phase_next;
    logic [13:0]  timer_reg, timer_next;
    logic [7:0]   quiet_reg, quiet_next;
    logic [7:0]   gap_reg, gap_next;
    logic [13:0]  lock_reg, lock_next;
    logic [7:0]   suspect_reg, suspect_next;
    logic [2:0]   held_reg, held_next;
    logic         out_valid_reg;
    bvlh_result_t out_reg, out_next;

    assign pop = q_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        logic [2:0]  fill_inc;
        logic [7:0]  gap_inc;
        logic [7:0]  quiet_inc;
        logic [13:0] lock_dec;
        logic [13:0] lock_dec_win;
        logic [13:0] timer_inc;
        logic        clr_hist;
        logic        note_hit;
        logic        reject;

        for (int i = 0; i < 4; i++)
        begin
            hist_next[i] = hist_reg[i];
        end
        fill_next    = fill_reg;
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        quiet_next   = quiet_reg;
        gap_next     = gap_reg;
        lock_next    = lock_reg;
        suspect_next = suspect_reg;
        held_next    = held_reg;
        clr_hist     = 1'b0;
        note_hit     = 1'b0;
        reject       = 1'b0;
        out_next     = '0;

        fill_inc     = (fill_reg < 3'd4) ? fill_reg + 3'd1 : fill_reg;
        gap_inc      = (gap_reg == 8'hFF) ? gap_reg : gap_reg + 8'd1;
        quiet_inc    = (quiet_reg == 8'hFF) ? quiet_reg : quiet_reg + 8'd1;
        lock_dec     = (lock_reg != '0) ? lock_reg - 14'd1 : lock_reg;
        timer_inc    = timer_reg + 14'd1;
        lock_dec_win = lock_dec;

        if (!q_item.is_tick)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    gap_next = '0;
                    if (!q_item.filler)
                    begin
                        hist_next[0] = hist_reg[1];
                        hist_next[1] = hist_reg[2];
                        hist_next[2] = hist_reg[3];
                        hist_next[3] = q_item.rx_byte;
                        fill_next    = fill_inc;
                        if (cfg.mode_u)
                        begin
                            if (q_item.suspect)
                            begin
                                if (lock_reg != '0)
                                begin
                                    lock_next = cfg.lock_window;
                                end
                                else if (suspect_reg != 8'hFF)
                                begin
                                    suspect_next = suspect_reg + 8'd1;
                                end
                            end
                            if (fill_inc >= 3'd2 && hist_reg[3] == BYTE_PWR_HDR
                                && q_item.rx_byte == BYTE_ESC)
                            begin
                                out_next.tx_valid = 1'b1;
                                out_next.tx_byte  = BYTE_ACCEPT;
                                out_next.outcome  = OUT_POWER_ON;
                            end
                            else if (fill_inc >= 3'd3 && hist_reg[2] == BYTE_NOTE_HDR
                                     && hist_reg[3] == BYTE_ESC && q_item.note_code)
                            begin
                                note_hit = 1'b1;
                            end
                        end
                        else
                        begin
                            if (fill_inc >= 3'd4 && hist_reg[1] == BYTE_PWR_HDR
                                && hist_reg[2] == BYTE_ESC && hist_reg[3] == BYTE_V_PWR_A
                                && q_item.rx_byte == BYTE_V_PWR_B)
                            begin
                                out_next.tx_valid = 1'b1;
                                out_next.tx_byte  = BYTE_ACCEPT;
                                out_next.outcome  = OUT_POWER_ON;
                            end
                            else if (fill_inc >= 3'd2 && hist_reg[3] == BYTE_NOTE_HDR
                                     && q_item.note_code)
                            begin
                                note_hit = 1'b1;
                            end
                        end
                        if (note_hit)
                        begin
                            held_next  = q_item.note_ch;
                            clr_hist   = 1'b1;
                            phase_next = PH_SETTLE;
                            timer_next = '0;
                            quiet_next = '0;
                        end
                    end
                end
                PH_SETTLE:
                begin
                end
                PH_DRAIN:
                begin
                    quiet_next = '0;
                end
                PH_AWAIT:
                begin
                    out_next.note_channel = held_reg;
                    if (q_item.stacked)
                    begin
                        out_next.outcome    = OUT_STACKED;
                        out_next.note_value = face_value(held_reg);
                    end
                    else
                    begin
                        out_next.outcome = OUT_REJECTED;
                    end
                    clr_hist   = 1'b1;
                    phase_next = PH_HUNT;
                    timer_next = '0;
                    quiet_next = '0;
                    gap_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            lock_next = lock_dec;
            unique case (phase_reg)
                PH_HUNT:
                begin
                    gap_next = gap_inc;
                    if (gap_inc >= cfg.burst_gap)
                    begin
                        clr_hist = 1'b1;
                    end
                end
                PH_SETTLE:
                begin
                    timer_next = timer_inc;
                    if (timer_inc >= {6'd0, cfg.settle_ticks})
                    begin
                        phase_next = PH_DRAIN;
                        timer_next = '0;
                        quiet_next = '0;
                    end
                end
                PH_DRAIN:
                begin
                    quiet_next = quiet_inc;
                    if (quiet_inc >= cfg.quiet_ticks)
                    begin
                        // channel zero lockout decision
                        if (cfg.mode_u && held_reg == 3'd0)
                        begin
                            if (suspect_reg >= cfg.lock_threshold)
                            begin
                                lock_dec_win = cfg.lock_window;
                            end
                            reject = (lock_dec_win != '0);
                        end
                        lock_next    = reject ? lock_dec_win : '0;
                        suspect_next = '0;
                        out_next.tx_valid     = 1'b1;
                        out_next.tx_byte      = reject ? BYTE_REJECT : BYTE_ACCEPT;
                        out_next.note_channel = held_reg;
                        phase_next = PH_AWAIT;
                        timer_next = '0;
                        quiet_next = '0;
                    end
                end
                PH_AWAIT:
                begin
                    if (timer_reg >= cfg.result_timeout)
                    begin
                        out_next.outcome      = OUT_TIMEOUT;
                        out_next.note_channel = held_reg;
                        clr_hist   = 1'b1;
                        phase_next = PH_HUNT;
                        timer_next = '0;
                        quiet_next = '0;
                        gap_next   = '0;
                    end
                    else
                    begin
                        timer_next = timer_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (clr_hist)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hist_next[i] = '0;
            end
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hist_reg[i] <= '0;
            end
            fill_reg      <= '0;
            phase_reg     <= PH_HUNT;
            timer_reg     <= '0;
            quiet_reg     <= '0;
            gap_reg       <= '0;
            lock_reg      <= '0;
            suspect_reg   <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    hist_reg[i] <= hist_next[i];
                end
                fill_reg    <= fill_next;
                phase_reg   <= phase_next;
                timer_reg   <= timer_next;
                quiet_reg   <= quiet_next;
                gap_reg     <= gap_next;
                lock_reg    <= lock_next;
                suspect_reg <= suspect_next;
                held_reg    <= held_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.tx_valid     = out_reg.tx_valid;
    assign rsp.tx_byte      = out_reg.tx_byte;
    assign rsp.outcome      = out_reg.outcome;
    assign rsp.note_channel = out_reg.note_channel;
    assign rsp.note_value   = out_reg.note_value;

endmodule
